// ===== src/tempo_map_position_convert_top_macros.svh =====
// assertion macros for the rtl of the tempo map converter
// included by the module that carries concurrent checks; needs clk and rst in scope
`ifndef TEMPO_MAP_POSITION_CONVERT_TOP_MACROS_SVH
`define TEMPO_MAP_POSITION_CONVERT_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define TMPC_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define TMPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TMPC_ASSERT(label, ante, cons, msg)
`define TMPC_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ===== src/tmpc_pkg.sv =====
// constants and codes for the tempo map position converter
// no dependencies; imported by tempo_map_position_convert_top and the testbench
`default_nettype none
package tmpc_pkg;
  localparam int PosW = 40;
  localparam int CntW = 7;
  localparam int IdxW = 6;
  localparam int ProdW = 2 * PosW;

  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_Q2T  = 2'd1;
  localparam logic [1:0] CMD_T2Q  = 2'd2;

  localparam logic CFG_MAP_ENABLED = 1'b0;
  localparam logic CFG_ENTRY_COUNT = 1'b1;
endpackage
`default_nettype wire

// ===== src/tempo_map_position_convert_top.sv =====
// tempo map position converter: one map memory, scan, serial multiply and divide
// depends on tmpc_pkg and tempo_map_position_convert_top_macros.svh
//
// usage:
//  s_* channel takes one 128-bit word per item: a load (cmd 0) writes one map
//  entry and gives no result; a query (cmd 1 quarter->time, cmd 2 time->quarter)
//  gives one result word on the m_* channel.
//  cfg_* channel writes map_enabled (index 0) and entry_count (index 1); it is
//  always ready and is meant to be used while the block is idle.
//  one item is worked on at a time. a query walks the map memory one entry per
//  cycle (one read port, registered read) until it finds the segment,
//  then runs a two-step multiply and an 80-step restoring divide.
//  a disabled map or empty count skips the scan and gives an invalid result.
//  the result sits in an output register; the next item is taken while it
//  waits, but a finished query holds the block until m_tready frees that
//  register. reset (rst, synchronous) clears the control state and config;
//  map memory contents are undefined until loaded.
`default_nettype none
`include "tempo_map_position_convert_top_macros.svh"
module tempo_map_position_convert_top
  import tmpc_pkg::*;
#(
  parameter int MAX_ENTRIES = 64
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // cmd[1:0], entry_index[7:2], entry_quarter[47:8], entry_time[87:48],
  // query_value[127:88]
  input  wire logic [127:0] s_tdata,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // result_value[39:0], result_valid[40], zero fill [47:41]
  output logic [47:0]       m_tdata,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic         cfg_index,
  input  wire logic [6:0]   cfg_data
);
  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int HalfW = PosW / 2;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_MUL, ST_DIV, ST_FIN, ST_OUT
  } state_t;

  state_t state;

  logic [2*PosW-1:0] mem [MAX_ENTRIES];
  logic [2*PosW-1:0] mem_rd;
  logic [AW-1:0]     rd_addr;
  logic [AW-1:0]     didx;
  logic              dvalid;

  logic              map_enabled;
  logic [CntW-1:0]   entry_count;
  logic [CW-1:0]     cnt;

  logic              t2q;
  logic [PosW-1:0]   qv;
  logic [PosW-1:0]   pkey, pval;
  logic [PosW-1:0]   va, dq, dv, dk;
  logic              neg;
  logic              mph;
  logic [ProdW-1:0]  prod;
  logic [PosW:0]     rem;
  logic [PosW+1:0]   quo;
  logic              sat;
  logic [6:0]        step;
  logic [PosW-1:0]   res_val;
  logic              res_ok;

  // input fields
  logic [1:0]        in_cmd;
  logic [IdxW-1:0]   in_idx;
  logic [PosW-1:0]   in_quarter, in_time, in_query;
  assign in_cmd     = s_tdata[1:0];
  assign in_idx     = s_tdata[7:2];
  assign in_quarter = s_tdata[47:8];
  assign in_time    = s_tdata[87:48];
  assign in_query   = s_tdata[127:88];

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    if (int'(entry_count) > MAX_ENTRIES) cnt = CW'(MAX_ENTRIES);
    else cnt = CW'(entry_count);
  end

  // key and value of the entry now on the read port
  logic [PosW-1:0] ckey, cval;
  assign ckey = t2q ? mem_rd[2*PosW-1:PosW] : mem_rd[PosW-1:0];
  assign cval = t2q ? mem_rd[PosW-1:0] : mem_rd[2*PosW-1:PosW];

  logic load_hit;
  assign load_hit = s_tvalid && s_tready && (in_cmd == CMD_LOAD)
                    && (int'(in_idx) < MAX_ENTRIES);

  always_ff @(posedge clk) begin
    if (load_hit) begin
      mem[AW'(in_idx)] <= {in_time, in_quarter};
    end
    mem_rd <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      map_enabled <= 1'b0;
      entry_count <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MAP_ENABLED: map_enabled <= cfg_data[0];
        CFG_ENTRY_COUNT: entry_count <= cfg_data;
        default: ;
      endcase
    end
  end

  // one half of dq times dv per multiply cycle
  logic [HalfW+PosW-1:0] pp;
  assign pp = (mph ? dq[PosW-1:HalfW] : dq[HalfW-1:0]) * dv;

  // divide step
  logic [PosW:0]   rem_sh;
  logic            qbit;
  assign rem_sh = {rem[PosW-1:0], prod[ProdW-1]};
  assign qbit   = (rem_sh >= {1'b0, dk});

  // final add with clamp
  logic [PosW+1:0]   quo_f;
  logic signed [PosW+2:0] sum;
  always_comb begin
    quo_f = (sat || quo > {1'b1, {(PosW+1){1'b0}}} >> 0 ? 1'b1 : 1'b0)
            ? (PosW+2)'(1) << (PosW+1) : quo;
    if (neg) sum = $signed({3'b000, va}) - $signed({1'b0, quo_f});
    else     sum = $signed({3'b000, va}) + $signed({1'b0, quo_f});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
      dvalid   <= 1'b0;
      rd_addr  <= '0;
    end else begin
      if (m_tvalid && m_tready && state != ST_OUT) m_tvalid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (s_tvalid && (in_cmd == CMD_Q2T || in_cmd == CMD_T2Q)) begin
            t2q     <= (in_cmd == CMD_T2Q);
            qv      <= in_query;
            rd_addr <= '0;
            dvalid  <= 1'b0;
            if (!map_enabled || cnt == '0) begin
              res_ok  <= 1'b0;
              res_val <= '0;
              state   <= ST_OUT;
            end else begin
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          rd_addr <= rd_addr + AW'(1);
          didx    <= rd_addr;
          dvalid  <= 1'b1;
          if (dvalid) begin
            if (didx == '0) begin
              pkey <= ckey;
              pval <= cval;
              if (cnt == CW'(1)) begin
                res_ok  <= (ckey == qv);
                res_val <= (ckey == qv) ? cval : '0;
                state   <= ST_OUT;
              end
            end else if (ckey >= qv || CW'(didx) == cnt - CW'(1)) begin
              if (pkey == ckey) begin
                res_ok  <= 1'b0;
                res_val <= '0;
                state   <= ST_OUT;
              end else begin
                va   <= pval;
                dk   <= (ckey > pkey) ? ckey - pkey : pkey - ckey;
                dq   <= (qv >= pkey) ? qv - pkey : pkey - qv;
                dv   <= (cval >= pval) ? cval - pval : pval - cval;
                neg  <= (ckey < pkey) ^ (qv < pkey) ^ (cval < pval);
                mph  <= 1'b0;
                state <= ST_MUL;
              end
            end else begin
              pkey <= ckey;
              pval <= cval;
            end
          end
        end
        ST_MUL: begin
          // two partial products of half of dq times dv
          mph <= 1'b1;
          if (!mph) begin
            prod <= ProdW'(pp);
          end else begin
            prod  <= prod + (ProdW'(pp) << HalfW);
            rem   <= '0;
            quo   <= '0;
            sat   <= 1'b0;
            step  <= '0;
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem  <= qbit ? rem_sh - {1'b0, dk} : rem_sh;
          quo  <= {quo[PosW:0], qbit};
          sat  <= sat | quo[PosW+1];
          prod <= {prod[ProdW-2:0], 1'b0};
          step <= step + 7'd1;
          if (step == 7'(ProdW - 1)) state <= ST_FIN;
        end
        ST_FIN: begin
          res_ok <= 1'b1;
          if (sum < 0) res_val <= '0;
          else if (sum[PosW+2:PosW] != 3'b000) res_val <= '1;
          else res_val <= sum[PosW-1:0];
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {7'b0, res_ok, res_val};
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `TMPC_ASSERT(a_div_nonzero, state == ST_DIV, dk != '0, "divide with zero spacing")
  `TMPC_ASSERT(a_invalid_zero, m_tvalid && !m_tdata[PosW], m_tdata[PosW-1:0] == '0,
    "invalid result carries a value")
  `TMPC_ASSERT(a_scan_bound, state == ST_SCAN && dvalid, CW'(didx) < cnt,
    "scan past last entry")
  `TMPC_ASSERT_NEXT(a_out_hold, state == ST_OUT && m_tvalid && !m_tready,
    state == ST_OUT, "result dropped while output busy")
endmodule
`default_nettype wire

// ===== test/testbench.sv =====
// self-checking testbench for tempo_map_position_convert_top
// depends on tmpc_pkg and the top level; loads tempo maps, runs conversions
`timescale 1ns / 1ps
`default_nettype none
module testbench;
  import tmpc_pkg::*;

  typedef struct packed {
    logic        ok;
    logic [39:0] value;
  } conv_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [127:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [47:0]  m_tdata;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic         cfg_index = 1'b0;
  logic [6:0]   cfg_data = '0;

  // model copy of the map and registers
  logic [39:0] quarter_map [64];
  logic [39:0] time_map [64];
  logic        map_on;
  logic [6:0]  map_count;

  conv_t expected_conv [$];
  int    mismatches;
  int    conversions_seen;
  int    send_idle_pct;
  int    recv_stall_pct;

  tempo_map_position_convert_top DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  initial begin
    #50ms;
    $display("testbench failed");
    $finish;
  end

  function automatic conv_t convert_pos(input logic [1:0] cmd, input logic [39:0] q);
    logic [39:0] keys [64];
    logic [39:0] vals [64];
    int          cnt;
    int          r;
    logic [39:0] ka, kb, va, vb;
    logic [40:0] dk, dq, dv;
    logic [81:0] prod;
    logic [81:0] quo;
    bit          neg;
    logic signed [83:0] sum;
    conv_t       res;
    res = '0;
    for (int i = 0; i < 64; i++) begin
      keys[i] = (cmd == CMD_Q2T) ? quarter_map[i] : time_map[i];
      vals[i] = (cmd == CMD_Q2T) ? time_map[i] : quarter_map[i];
    end
    cnt = (map_count > 64) ? 64 : map_count;
    if (!map_on || cnt == 0) return res;
    if (cnt == 1) begin
      if (q == keys[0]) begin
        res.ok = 1'b1;
        res.value = vals[0];
      end
      return res;
    end
    r = 1;
    while (r < cnt && keys[r] < q) r++;
    if (r >= cnt) r = cnt - 1;
    ka = keys[r-1]; kb = keys[r]; va = vals[r-1]; vb = vals[r];
    if (ka == kb) return res;
    neg = 1'b0;
    if (kb > ka) dk = kb - ka; else begin dk = ka - kb; neg = !neg; end
    if (q >= ka) dq = q - ka; else begin dq = ka - q; neg = !neg; end
    if (vb >= va) dv = vb - va; else begin dv = va - vb; neg = !neg; end
    prod = dq * dv;
    quo = prod / dk;
    // quotient cap does not change the saturated outcome
    if (quo > (82'd1 << 41)) quo = 82'd1 << 41;
    sum = neg ? $signed({2'b0, va}) - $signed({2'b0, quo})
              : $signed({2'b0, va}) + $signed({2'b0, quo});
    if (sum < 0) sum = 0;
    if (sum > 84'hFF_FFFF_FFFF) sum = 84'hFF_FFFF_FFFF;
    res.ok = 1'b1;
    res.value = sum[39:0];
    return res;
  endfunction

  // tvalid stays up after the word so the next one can follow back to back
  task automatic send_word(input logic [1:0] cmd, input logic [5:0] idx,
                           input logic [39:0] eq, input logic [39:0] et,
                           input logic [39:0] qv);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tdata <= {qv, et, eq, idx, cmd};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (cmd == CMD_LOAD) begin
      quarter_map[idx] = eq;
      time_map[idx] = et;
    end else if (cmd == CMD_Q2T || cmd == CMD_T2Q) begin
      expected_conv.push_back(convert_pos(cmd, qv));
    end
    @(negedge clk);
  endtask

  task automatic wait_idle;
    int guard;
    guard = 0;
    s_tvalid <= 1'b0;
    while (expected_conv.size() != 0 && guard < 200000) begin
      @(negedge clk);
      guard++;
    end
    repeat (200) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [6:0] val);
    wait_idle();
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_MAP_ENABLED) map_on = val[0];
    else map_count = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [39:0] rand40;
    return {8'($urandom_range(255)), $urandom()};
  endfunction

  // query value random or near map keys to hit segments and exact matches
  function automatic logic [39:0] pick_query(input logic [1:0] cmd);
    int          i;
    logic [39:0] k;
    i = $urandom_range(63);
    k = (cmd == CMD_Q2T) ? quarter_map[i] : time_map[i];
    case ($urandom_range(3))
      0: return rand40();
      1: return k;
      2: return k + $urandom_range(1000);
      default: return k - $urandom_range(1000);
    endcase
  endfunction

  // load a map of count entries, keys mostly increasing unless wild (then random)
  task automatic load_map(input int cnt, input bit wild);
    logic [39:0] q, t;
    q = wild ? rand40() : $urandom_range(1000);
    t = wild ? rand40() : $urandom_range(1000);
    for (int i = 0; i < cnt; i++) begin
      send_word(CMD_LOAD, i[5:0], q, t, rand40());
      if (wild) begin
        q = rand40(); t = rand40();
      end else begin
        q = q + (($urandom_range(9) == 0) ? 0 : $urandom_range(1 << 22));
        t = t + (($urandom_range(9) == 0) ? 0 : $urandom_range(1 << 22));
      end
    end
  endtask

  task automatic test_directed;
    logic [39:0] mx;
    mx = '1;
    send_word(CMD_Q2T, 6'd0, '0, '0, 40'd5);     // disabled map
    write_reg(CFG_MAP_ENABLED, 7'd1);
    send_word(CMD_T2Q, 6'd0, '0, '0, 40'd5);     // empty count
    send_word(CMD_LOAD, 6'd0, 40'd100, 40'd200, '0);
    send_word(CMD_LOAD, 6'd1, mx, mx, mx);
    send_word(CMD_LOAD, 6'd63, 40'd7, mx, '0);
    send_word(2'd3, 6'd5, mx, mx, mx);           // ignored command
    write_reg(CFG_ENTRY_COUNT, 7'd1);
    send_word(CMD_Q2T, 6'd0, '0, '0, 40'd100);   // single entry, exact
    send_word(CMD_Q2T, 6'd0, '0, '0, 40'd101);   // single entry, no match
    send_word(CMD_T2Q, 6'd0, '0, '0, 40'd200);
    write_reg(CFG_ENTRY_COUNT, 7'd2);
    send_word(CMD_Q2T, 6'd0, '0, '0, '0);        // extrapolate below
    send_word(CMD_Q2T, 6'd0, '0, '0, mx);
    send_word(CMD_T2Q, 6'd0, '0, '0, 40'd12345);
    send_word(CMD_LOAD, 6'd1, 40'd100, 40'd0, '0);
    send_word(CMD_Q2T, 6'd0, '0, '0, 40'd50);    // zero spacing
    send_word(CMD_LOAD, 6'd1, 40'd101, mx, '0);
    send_word(CMD_Q2T, 6'd0, '0, '0, mx);        // saturate high
    send_word(CMD_LOAD, 6'd1, 40'd101, 40'd0, '0);
    send_word(CMD_Q2T, 6'd0, '0, '0, mx);        // saturate low
    write_reg(CFG_ENTRY_COUNT, 7'd0);
    send_word(CMD_Q2T, 6'd0, '0, '0, 40'd100);
  endtask

  task automatic test_random(input int n, input int sidle, input int rstall);
    int          kind;
    logic [1:0]  cmd;
    logic [6:0]  cnt;
    send_idle_pct = sidle;
    recv_stall_pct = rstall;
    for (int blk = 0; blk < n / 60; blk++) begin
      case ($urandom_range(5))
        0: cnt = 7'd64 + 7'($urandom_range(63));     // at or above max, clamps to 64
        1: cnt = 7'd1 + 7'($urandom_range(1));
        default: cnt = 7'd2 + 7'($urandom_range(14));
      endcase
      load_map(cnt > 64 ? 64 : cnt, $urandom_range(4) == 0);
      write_reg(CFG_ENTRY_COUNT, cnt);
      write_reg(CFG_MAP_ENABLED, {6'd0, ($urandom_range(9) != 0)});
      for (int i = 0; i < 45; i++) begin
        kind = $urandom_range(19);
        if (kind == 0) begin
          send_word(2'd3, 6'($urandom()), rand40(), rand40(), rand40());
        end else begin
          cmd = (kind < 10) ? CMD_Q2T : CMD_T2Q;
          send_word(cmd, 6'($urandom()), rand40(), rand40(), pick_query(cmd));
        end
      end
    end
  endtask

  // result checker
  always @(posedge clk) begin
    conv_t exp_c;
    if (!rst && m_tvalid && m_tready) begin
      conversions_seen++;
      if (expected_conv.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h", m_tdata);
      end else begin
        exp_c = expected_conv.pop_front();
        if (m_tdata[40] !== exp_c.ok || m_tdata[39:0] !== exp_c.value ||
            m_tdata[47:41] !== 7'd0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected valid %0d value %h, got valid %0d value %h",
                     exp_c.ok, exp_c.value, m_tdata[40], m_tdata[39:0]);
        end
      end
    end
  end

  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin
    mismatches = 0;
    conversions_seen = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    map_on = 1'b0;
    map_count = '0;
    for (int i = 0; i < 64; i++) begin
      quarter_map[i] = '0; time_map[i] = '0;
    end
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(480, 0, 0);
    test_random(480, 45, 0);
    test_random(480, 0, 45);
    test_random(480, 14, 14);
    wait_idle();
    $display("ran directed edge cases and random maps with %0d conversions checked",
             conversions_seen);
    if (mismatches == 0 && expected_conv.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("%0d mismatches, %0d words missing", mismatches, expected_conv.size());
      $display("testbench failed");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== filelist.f =====
+incdir+src
src/tmpc_pkg.sv
src/tempo_map_position_convert_top.sv
test/testbench.sv
